// ===== hw/rtl/ata_pio_sector_sequencer_top_assert.svh =====
// ----------------------------------------------------------------------------
// ATA PIO sector sequencer assertion macros
// Shared property wrappers for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_SECTOR_SEQUENCER_TOP_ASSERT_SVH
`define ATA_PIO_SECTOR_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define APSS_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("apss assertion failed");

// Next-cycle implication, disabled during reset
`define APSS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("apss assertion failed");

`endif

// ===== hw/rtl/apss_pkg.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sector sequencer package
// Types, register codes and ATA constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package apss_pkg;

  // Sector geometry
  localparam int unsigned WORDS_PER_SECTOR = 256;
  localparam int unsigned WordW            = $clog2(WORDS_PER_SECTOR);
  localparam int unsigned SectorBytes      = 2 * WORDS_PER_SECTOR;
  localparam int unsigned TotalW           = 25;
  localparam int unsigned TotalFullW       = 16 + $clog2(SectorBytes + 1);
  localparam logic [TotalW-1:0] TOTAL_MAX  = {TotalW{1'b1}};

  // Task queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // LBA28 boundary
  localparam logic [47:0] LBA28_LIMIT    = 48'h0000_0FFF_FFFF;
  localparam logic [47:0] LBA28_LIMIT_M1 = LBA28_LIMIT - 48'd1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam logic [CfgIdxW-1:0] CFG_COMMAND_BASE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONTROL_BASE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_SELECT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LBA48        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT   = 3'd4;

  // Configuration reset values
  localparam logic [15:0] CMD_BASE_RESET   = 16'h01F0;
  localparam logic [15:0] CTRL_BASE_RESET  = 16'h03F6;
  localparam logic [19:0] POLL_LIMIT_RESET = 20'd100000;

  // Input opcodes
  localparam logic [2:0] OP_START_RD  = 3'd0;
  localparam logic [2:0] OP_START_WR  = 3'd1;
  localparam logic [2:0] OP_STATUS    = 3'd2;
  localparam logic [2:0] OP_DEV_DATA  = 3'd3;
  localparam logic [2:0] OP_HOST_DATA = 3'd4;

  // Task-file register offsets
  localparam logic [15:0] OFS_DATA   = 16'd0;
  localparam logic [15:0] OFS_FEAT   = 16'd1;
  localparam logic [15:0] OFS_COUNT  = 16'd2;
  localparam logic [15:0] OFS_LBA0   = 16'd3;
  localparam logic [15:0] OFS_LBA1   = 16'd4;
  localparam logic [15:0] OFS_LBA2   = 16'd5;
  localparam logic [15:0] OFS_DEVSEL = 16'd6;
  localparam logic [15:0] OFS_CMD    = 16'd7;
  localparam logic [15:0] OFS_ALT    = 16'd2;

  // ATA command bytes
  localparam logic [7:0] CMD_READ_PIO      = 8'h20;
  localparam logic [7:0] CMD_READ_PIO_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE_PIO     = 8'h30;
  localparam logic [7:0] CMD_WRITE_PIO_EXT = 8'h34;
  localparam logic [7:0] CMD_FLUSH         = 8'hE7;
  localparam logic [7:0] CMD_FLUSH_EXT     = 8'hEA;

  // Device select bytes
  localparam logic [7:0] DEVSEL_LBA28 = 8'hE0;
  localparam logic [7:0] DEVSEL_LBA48 = 8'h40;

  // Status bits
  localparam int unsigned ST_ERR_BIT = 0;
  localparam int unsigned ST_DRQ_BIT = 3;
  localparam int unsigned ST_DF_BIT  = 5;
  localparam int unsigned ST_BSY_BIT = 7;
  localparam logic [7:0] STATUS_FLOAT = 8'hFF;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_BYTE_WR   = 3'd0,
    KIND_BYTE_RD   = 3'd1,
    KIND_WORD_WR   = 3'd2,
    KIND_WORD_RD   = 3'd3,
    KIND_HOST_DATA = 3'd4,
    KIND_HOST_WANT = 3'd5,
    KIND_DONE      = 3'd6,
    KIND_FAIL      = 3'd7
  } kind_e;

  // Front phase
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_POLL_DATA  = 3'd1,
    PH_READ_DATA  = 3'd2,
    PH_WRITE_DATA = 3'd3,
    PH_POLL_FLUSH = 3'd4
  } phase_e;

  // Back sequencer state
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_PRE  = 2'd1,
    BK_BODY = 2'd2
  } back_state_e;

  // Leading result of a task
  typedef enum logic [1:0] {
    PRE_NONE = 2'd0,
    PRE_HOST = 2'd1,
    PRE_WWR  = 2'd2
  } pre_e;

  // Main result sequence of a task
  typedef enum logic [2:0] {
    BODY_FAIL  = 3'd0,
    BODY_WANT  = 3'd1,
    BODY_WRD   = 3'd2,
    BODY_POLL  = 3'd3,
    BODY_DONE  = 3'd4,
    BODY_ISSUE = 3'd5,
    BODY_FLUSH = 3'd6
  } body_e;

  typedef struct packed {
    logic [15:0] command_base;
    logic [15:0] control_base;
    logic        drive_select;
    logic        lba48_capable;
    logic [19:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [47:0] lba;
    logic [15:0] sector_count;
    logic [15:0] item_value;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] port_address;
    logic [15:0] out_value;
    logic [24:0] byte_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    pre_e              pre;
    body_e             body;
    logic [15:0]       value;
    logic [7:0]        cmd;
    logic              ext;
    logic [47:0]       lba;
    logic [TotalW-1:0] total;
  } task_t;

endpackage

`default_nettype wire

// ===== hw/rtl/apss_front.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer front end
// Accepts items, tracks the transfer phase and queues at most one task per item.
// ----------------------------------------------------------------------------
`default_nettype none

module apss_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  apss_pkg::cfg_t       cfg_i,
  input  wire                  in_valid_i,
  input  apss_pkg::in_item_t   in_item_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output apss_pkg::task_t      task_o
);

  apss_pkg::phase_e                phase_q, phase_d;
  logic [47:0]                     lba_q, lba_d;
  logic [15:0]                     count_q, count_d;
  logic [15:0]                     done_q, done_d;
  logic [apss_pkg::WordW-1:0]      word_q, word_d;
  logic [19:0]                     poll_q, poll_d;
  logic                            is_write_q, is_write_d;

  logic                            accept;
  logic [7:0]                      status;
  logic                            st_bad;
  logic                            st_ready;
  logic                            st_busy;
  logic                            poll_over;
  logic                            last_word;
  logic                            finish;
  logic                            start_ext;
  logic                            next_ext;
  logic [47:0]                     lba_next;
  logic [15:0]                     done_next;
  logic [apss_pkg::TotalFullW-1:0] total_full;
  logic [apss_pkg::TotalW-1:0]     total_sat;

  // Pick the read or write PIO command for the addressing form
  function automatic logic [7:0] issue_cmd(input logic ext, input logic wr);
    logic [7:0] c;
    if (ext) begin
      c = wr ? apss_pkg::CMD_WRITE_PIO_EXT : apss_pkg::CMD_READ_PIO_EXT;
    end else begin
      c = wr ? apss_pkg::CMD_WRITE_PIO : apss_pkg::CMD_READ_PIO;
    end
    return c;
  endfunction

  assign accept = in_valid_i && !q_full_i;

  // Classify the status byte
  assign status    = in_item_i.item_value[7:0];
  assign st_bad    = (status == apss_pkg::STATUS_FLOAT) || status[apss_pkg::ST_ERR_BIT]
                     || status[apss_pkg::ST_DF_BIT];
  assign st_busy   = status[apss_pkg::ST_BSY_BIT];
  assign st_ready  = !st_busy && status[apss_pkg::ST_DRQ_BIT];
  assign poll_over = poll_q >= cfg_i.poll_limit;
  assign last_word = word_q == apss_pkg::WordW'(apss_pkg::WORDS_PER_SECTOR - 1);

  // Decide the addressing form for a fresh request
  assign start_ext = cfg_i.lba48_capable
                     && ((in_item_i.lba >= apss_pkg::LBA28_LIMIT)
                         || (({1'b0, in_item_i.lba} + 49'(in_item_i.sector_count))
                             > {1'b0, apss_pkg::LBA28_LIMIT}));

  // Decide the form for the following sector, folding in the increment
  assign lba_next  = lba_q + 48'd1;
  assign done_next = done_q + 16'd1;
  assign next_ext  = cfg_i.lba48_capable && !(&lba_q)
                     && ((lba_q >= apss_pkg::LBA28_LIMIT_M1)
                         || (({1'b0, lba_q} + 49'(count_q)) >= {1'b0, apss_pkg::LBA28_LIMIT}));

  // Byte total, saturated to the result field
  assign total_full = apss_pkg::TotalFullW'(count_q)
                      * apss_pkg::TotalFullW'(apss_pkg::SectorBytes);
  assign total_sat  = (total_full > apss_pkg::TotalFullW'(apss_pkg::TOTAL_MAX))
                      ? apss_pkg::TOTAL_MAX : total_full[apss_pkg::TotalW-1:0];

  // Hold the transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= apss_pkg::PH_IDLE;
      lba_q      <= '0;
      count_q    <= '0;
      done_q     <= '0;
      word_q     <= '0;
      poll_q     <= '0;
      is_write_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      lba_q      <= lba_d;
      count_q    <= count_d;
      done_q     <= done_d;
      word_q     <= word_d;
      poll_q     <= poll_d;
      is_write_q <= is_write_d;
    end
  end

  // Advance the phase and build the task for the accepted item
  always_comb begin
    phase_d    = phase_q;
    lba_d      = lba_q;
    count_d    = count_q;
    done_d     = done_q;
    word_d     = word_q;
    poll_d     = poll_q;
    is_write_d = is_write_q;
    finish     = 1'b0;
    push_o     = 1'b0;

    task_o.pre   = apss_pkg::PRE_NONE;
    task_o.body  = apss_pkg::BODY_FAIL;
    task_o.value = in_item_i.item_value;
    task_o.cmd   = '0;
    task_o.ext   = 1'b0;
    task_o.lba   = lba_q;
    task_o.total = '0;

    if (accept) begin
      case (phase_q)
        apss_pkg::PH_IDLE: begin
          if (in_item_i.opcode inside {apss_pkg::OP_START_RD, apss_pkg::OP_START_WR}) begin
            push_o = 1'b1;
            if (in_item_i.sector_count != 16'd0) begin
              is_write_d  = in_item_i.opcode == apss_pkg::OP_START_WR;
              lba_d       = in_item_i.lba;
              count_d     = in_item_i.sector_count;
              done_d      = '0;
              task_o.body = apss_pkg::BODY_ISSUE;
              task_o.ext  = start_ext;
              task_o.lba  = in_item_i.lba;
              task_o.cmd  = issue_cmd(start_ext,
                                      in_item_i.opcode == apss_pkg::OP_START_WR);
              phase_d     = apss_pkg::PH_POLL_DATA;
              poll_d      = 20'd1;
              word_d      = '0;
            end
          end
        end
        apss_pkg::PH_POLL_DATA: begin
          if (in_item_i.opcode == apss_pkg::OP_STATUS) begin
            push_o = 1'b1;
            if (st_bad) begin
              phase_d = apss_pkg::PH_IDLE;
            end else if (st_ready) begin
              if (is_write_q) begin
                phase_d     = apss_pkg::PH_WRITE_DATA;
                task_o.body = apss_pkg::BODY_WANT;
              end else begin
                phase_d     = apss_pkg::PH_READ_DATA;
                task_o.body = apss_pkg::BODY_WRD;
              end
            end else if (poll_over) begin
              phase_d = apss_pkg::PH_IDLE;
            end else begin
              poll_d      = poll_q + 20'd1;
              task_o.body = apss_pkg::BODY_POLL;
            end
          end
        end
        apss_pkg::PH_POLL_FLUSH: begin
          if (in_item_i.opcode == apss_pkg::OP_STATUS) begin
            push_o = 1'b1;
            if (st_bad || !st_busy || poll_over) begin
              finish = 1'b1;
            end else begin
              poll_d      = poll_q + 20'd1;
              task_o.body = apss_pkg::BODY_POLL;
            end
          end
        end
        apss_pkg::PH_READ_DATA: begin
          if (in_item_i.opcode == apss_pkg::OP_DEV_DATA) begin
            push_o     = 1'b1;
            task_o.pre = apss_pkg::PRE_HOST;
            word_d     = word_q + apss_pkg::WordW'(1);
            if (last_word) begin
              finish = 1'b1;
            end else begin
              task_o.body = apss_pkg::BODY_WRD;
            end
          end
        end
        apss_pkg::PH_WRITE_DATA: begin
          if (in_item_i.opcode == apss_pkg::OP_HOST_DATA) begin
            push_o     = 1'b1;
            task_o.pre = apss_pkg::PRE_WWR;
            word_d     = word_q + apss_pkg::WordW'(1);
            if (last_word) begin
              task_o.body = apss_pkg::BODY_FLUSH;
              task_o.cmd  = cfg_i.lba48_capable ? apss_pkg::CMD_FLUSH_EXT
                                                : apss_pkg::CMD_FLUSH;
              phase_d     = apss_pkg::PH_POLL_FLUSH;
              poll_d      = 20'd1;
            end else begin
              task_o.body = apss_pkg::BODY_WANT;
            end
          end
        end
        default: ;
      endcase

      // Close the sector: report completion or start the next one
      if (finish) begin
        done_d = done_next;
        lba_d  = lba_next;
        if (done_next >= count_q) begin
          task_o.body  = apss_pkg::BODY_DONE;
          task_o.total = total_sat;
          phase_d      = apss_pkg::PH_IDLE;
        end else begin
          task_o.body = apss_pkg::BODY_ISSUE;
          task_o.ext  = next_ext;
          task_o.lba  = lba_next;
          task_o.cmd  = issue_cmd(next_ext, is_write_q);
          phase_d     = apss_pkg::PH_POLL_DATA;
          poll_d      = 20'd1;
          word_d      = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/apss_queue.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer task queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module apss_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  apss_pkg::task_t  task_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output apss_pkg::task_t  task_o
);

  apss_pkg::task_t                   entry_q [apss_pkg::QueueDepth];
  logic [apss_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [apss_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [apss_pkg::QueueCntW-1:0]    count_q, count_d;

  assign full_o  = count_q == apss_pkg::QueueCntW'(apss_pkg::QueueDepth);
  assign valid_o = count_q != '0;
  assign task_o  = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == apss_pkg::QueuePtrW'(apss_pkg::QueueDepth - 1))
                 ? '0 : wr_ptr_q + apss_pkg::QueuePtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == apss_pkg::QueuePtrW'(apss_pkg::QueueDepth - 1))
                 ? '0 : rd_ptr_q + apss_pkg::QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + apss_pkg::QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - apss_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed task
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= task_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/apss_back.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer back end
// Expands queued tasks into result items, one per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ata_pio_sector_sequencer_top_assert.svh"

module apss_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  apss_pkg::cfg_t      cfg_i,
  input  wire                 q_valid_i,
  input  apss_pkg::task_t     q_task_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output apss_pkg::out_item_t out_item_o
);

  // Slots of the command issue sequence, in LBA48 order
  localparam logic [3:0] SLOT_DEVSEL    = 4'd0;
  localparam logic [3:0] SLOT_HOB_COUNT = 4'd1;
  localparam logic [3:0] SLOT_HOB_LBA0  = 4'd2;
  localparam logic [3:0] SLOT_HOB_LBA1  = 4'd3;
  localparam logic [3:0] SLOT_HOB_LBA2  = 4'd4;
  localparam logic [3:0] SLOT_COUNT     = 4'd5;
  localparam logic [3:0] SLOT_LBA0      = 4'd6;
  localparam logic [3:0] SLOT_LBA1      = 4'd7;
  localparam logic [3:0] SLOT_LBA2      = 4'd8;
  localparam logic [3:0] SLOT_CMD       = 4'd9;
  localparam logic [3:0] SLOT_ALT_FIRST = 4'd10;
  localparam logic [3:0] SLOT_ALT_LAST  = 4'd13;
  localparam logic [3:0] SLOT_STATUS    = 4'd14;
  localparam logic [3:0] SLOT_FEAT      = 4'd15;
  localparam logic [3:0] LBA28_SKIP     = 4'd3;

  apss_pkg::back_state_e state_q, state_d;
  apss_pkg::task_t       task_q, task_d;
  logic [3:0]            step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  apss_pkg::out_item_t   out_q, res;

  logic                  emit;
  logic                  emit_last;
  logic                  load;
  logic [3:0]            slot;
  logic [7:0]            dev_byte;
  logic [7:0]            wr_byte;

  // Number of body results of a task
  function automatic logic [3:0] body_len(input apss_pkg::task_t t);
    logic [3:0] n;
    case (t.body)
      apss_pkg::BODY_ISSUE: n = t.ext ? 4'd15 : 4'd12;
      apss_pkg::BODY_FLUSH: n = 4'd2;
      default:              n = 4'd1;
    endcase
    return n;
  endfunction

  assign emit      = (state_q != apss_pkg::BK_IDLE) && (!out_valid_q || !out_stall_i);
  assign emit_last = (state_q == apss_pkg::BK_BODY) && (step_q == body_len(task_q) - 4'd1);
  assign load      = q_valid_i && ((state_q == apss_pkg::BK_IDLE) || (emit && emit_last));
  assign q_pop_o   = load;

  // Map an issue step onto its slot; LBA28 skips the high-order writes
  always_comb begin
    if (task_q.ext || (step_q == 4'd0)) begin
      slot = step_q;
    end else if (step_q == 4'd1) begin
      slot = SLOT_FEAT;
    end else begin
      slot = step_q + LBA28_SKIP;
    end
  end

  assign dev_byte = task_q.ext
                    ? (apss_pkg::DEVSEL_LBA48 | {3'b000, cfg_i.drive_select, 4'b0000})
                    : (apss_pkg::DEVSEL_LBA28 | {3'b000, cfg_i.drive_select, 4'b0000}
                       | {4'b0000, task_q.lba[27:24]});

  // Build the result for the current step
  always_comb begin
    res              = '0;
    res.kind         = apss_pkg::KIND_FAIL;
    wr_byte          = '0;
    if (state_q == apss_pkg::BK_PRE) begin
      case (task_q.pre)
        apss_pkg::PRE_HOST: begin
          res.kind      = apss_pkg::KIND_HOST_DATA;
          res.out_value = task_q.value;
        end
        apss_pkg::PRE_WWR: begin
          res.kind         = apss_pkg::KIND_WORD_WR;
          res.port_address = cfg_i.command_base + apss_pkg::OFS_DATA;
          res.out_value    = task_q.value;
        end
        default: ;
      endcase
    end else begin
      case (task_q.body)
        apss_pkg::BODY_WANT: res.kind = apss_pkg::KIND_HOST_WANT;
        apss_pkg::BODY_WRD: begin
          res.kind         = apss_pkg::KIND_WORD_RD;
          res.port_address = cfg_i.command_base + apss_pkg::OFS_DATA;
        end
        apss_pkg::BODY_POLL: begin
          res.kind         = apss_pkg::KIND_BYTE_RD;
          res.port_address = cfg_i.command_base + apss_pkg::OFS_CMD;
        end
        apss_pkg::BODY_DONE: begin
          res.kind       = apss_pkg::KIND_DONE;
          res.byte_total = task_q.total;
        end
        apss_pkg::BODY_FLUSH: begin
          res.port_address = cfg_i.command_base + apss_pkg::OFS_CMD;
          if (step_q == 4'd0) begin
            res.kind      = apss_pkg::KIND_BYTE_WR;
            res.out_value = {8'h00, task_q.cmd};
          end else begin
            res.kind = apss_pkg::KIND_BYTE_RD;
          end
        end
        apss_pkg::BODY_ISSUE: begin
          res.kind = apss_pkg::KIND_BYTE_WR;
          case (slot)
            SLOT_DEVSEL: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_DEVSEL;
              wr_byte          = dev_byte;
            end
            SLOT_HOB_COUNT: res.port_address = cfg_i.command_base + apss_pkg::OFS_COUNT;
            SLOT_HOB_LBA0: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_LBA0;
              wr_byte          = task_q.lba[31:24];
            end
            SLOT_HOB_LBA1: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_LBA1;
              wr_byte          = task_q.lba[39:32];
            end
            SLOT_HOB_LBA2: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_LBA2;
              wr_byte          = task_q.lba[47:40];
            end
            SLOT_COUNT: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_COUNT;
              wr_byte          = 8'd1;
            end
            SLOT_LBA0: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_LBA0;
              wr_byte          = task_q.lba[7:0];
            end
            SLOT_LBA1: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_LBA1;
              wr_byte          = task_q.lba[15:8];
            end
            SLOT_LBA2: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_LBA2;
              wr_byte          = task_q.lba[23:16];
            end
            SLOT_CMD: begin
              res.port_address = cfg_i.command_base + apss_pkg::OFS_CMD;
              wr_byte          = task_q.cmd;
            end
            SLOT_STATUS: begin
              res.kind         = apss_pkg::KIND_BYTE_RD;
              res.port_address = cfg_i.command_base + apss_pkg::OFS_CMD;
            end
            SLOT_FEAT: res.port_address = cfg_i.command_base + apss_pkg::OFS_FEAT;
            default: begin
              // Alternate-status reads give the 400 ns settle delay
              if (slot inside {[SLOT_ALT_FIRST:SLOT_ALT_LAST]}) begin
                res.kind         = apss_pkg::KIND_BYTE_RD;
                res.port_address = cfg_i.control_base + apss_pkg::OFS_ALT;
              end
            end
          endcase
          res.out_value = {8'h00, wr_byte};
        end
        default: res.kind = apss_pkg::KIND_FAIL;
      endcase
      res.last = emit_last;
    end
  end

  // Sequence through the pre result and the body steps
  always_comb begin
    state_d     = state_q;
    task_d      = task_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (state_q == apss_pkg::BK_PRE) begin
        state_d = apss_pkg::BK_BODY;
      end else if (emit_last) begin
        state_d = apss_pkg::BK_IDLE;
      end else begin
        step_d = step_q + 4'd1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      task_d  = q_task_i;
      step_d  = '0;
      state_d = (q_task_i.pre == apss_pkg::PRE_NONE) ? apss_pkg::BK_BODY : apss_pkg::BK_PRE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apss_pkg::BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold task and output payload
  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `APSS_ASSERT_NEXT(a_pre_then_body, clk_i, rst_ni, emit && (state_q == apss_pkg::BK_PRE), state_q == apss_pkg::BK_BODY)
  `APSS_ASSERT_NOW(a_step_in_range, clk_i, rst_ni, state_q == apss_pkg::BK_BODY, step_q < body_len(task_q))
  `APSS_ASSERT_NEXT(a_last_ends_task, clk_i, rst_ni, emit && res.last, (state_q == apss_pkg::BK_IDLE) || (step_q == 4'd0))

endmodule

`default_nettype wire

// ===== hw/rtl/ata_pio_sector_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sector sequencer top level
// Host-side PIO command sequencer with LBA28/LBA48 addressing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries start requests,
//   device status bytes and data words. Output channel (out_valid_o /
//   out_stall_i / out_item_o) returns bus accesses, host data and completion.
//   Each item yields up to 16 result items; the final one has last set.
//   An accepted item passes the task queue and the back-end task register
//   before its first result is registered at the output. The back end gives
//   one result per cycle while the output is not stalled; the front end takes
//   one item per cycle while its 4-entry task queue has room. A sector issue
//   after the last read word of an LBA48 transfer yields 16 results.
//   A stalled output holds its item; the back end stops and the queue fills,
//   after which in_stall_o rises.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and are
//   meant for idle periods. Reset restores register defaults (base 0x1F0,
//   control 0x3F6, master, LBA28, poll limit 100000) and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_pio_sector_sequencer_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  apss_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output apss_pkg::out_item_t              out_item_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [apss_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire [apss_pkg::CfgDataW-1:0]     cfg_data_i
);

  apss_pkg::cfg_t  cfg_q;
  logic            q_full;
  logic            q_valid;
  logic            q_push;
  logic            q_pop;
  apss_pkg::task_t push_task;
  apss_pkg::task_t pop_task;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  // Update configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.command_base  <= apss_pkg::CMD_BASE_RESET;
      cfg_q.control_base  <= apss_pkg::CTRL_BASE_RESET;
      cfg_q.drive_select  <= 1'b0;
      cfg_q.lba48_capable <= 1'b0;
      cfg_q.poll_limit    <= apss_pkg::POLL_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        apss_pkg::CFG_COMMAND_BASE: cfg_q.command_base  <= cfg_data_i[15:0];
        apss_pkg::CFG_CONTROL_BASE: cfg_q.control_base  <= cfg_data_i[15:0];
        apss_pkg::CFG_DRIVE_SELECT: cfg_q.drive_select  <= cfg_data_i[0];
        apss_pkg::CFG_LBA48:        cfg_q.lba48_capable <= cfg_data_i[0];
        apss_pkg::CFG_POLL_LIMIT:   cfg_q.poll_limit    <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  apss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .task_o     (push_task)
  );

  apss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .task_i  (push_task),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .task_o  (pop_task)
  );

  apss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_task_i    (pop_task),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/ata_pio_sector_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sector sequencer testbench
// Drives start requests, status bytes and data words into the sequencer and
// checks every bus access, host word and completion against a cycle-free
// model of the host-side PIO protocol kept inside the bench. Directed items
// cover the addressing forms, status failures, poll timeouts and ignored
// items; phase-aware random traffic then runs whole sectors under four
// idle/stall patterns with different register settings.
// ----------------------------------------------------------------------------
module ata_pio_sector_sequencer_top_tb;
  import apss_pkg::*;

  logic clk;
  logic rst_n = 1'b0;

  logic                in_valid_q  = 1'b0;
  in_item_t            in_item_q   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_q = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_q = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_q = '0;
  logic [CfgDataW-1:0] cfg_data_q  = '0;

  // Idle and stall percentages of the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Run statistics
  int unsigned items_sent      = 0;
  int unsigned items_acted     = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned requests_done   = 0;
  int unsigned requests_failed = 0;

  // Sequencer model: registers and protocol state
  cfg_t        cfg_model;
  phase_e      ph;
  logic [47:0] cur_lba;
  logic [15:0] req_cnt;
  logic [15:0] secs_done;
  logic [8:0]  word_idx;
  logic [19:0] poll_cnt;
  logic        wr_flag;

  // Bus accesses and host results still owed by the sequencer
  out_item_t   expected_q[$];
  int unsigned step_results;

  ata_pio_sector_sequencer_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_q),
    .cfg_data_i  (cfg_data_q)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the sequencer hangs
  initial begin
    #10_000_000;
    $display("Timeout: sequencer stopped making progress");
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Protocol model
  // --------------------------------------------------------------------------

  function automatic void reset_model();
    cfg_model.command_base  = CMD_BASE_RESET;
    cfg_model.control_base  = CTRL_BASE_RESET;
    cfg_model.drive_select  = 1'b0;
    cfg_model.lba48_capable = 1'b0;
    cfg_model.poll_limit    = POLL_LIMIT_RESET;
    ph        = PH_IDLE;
    cur_lba   = '0;
    req_cnt   = '0;
    secs_done = '0;
    word_idx  = '0;
    poll_cnt  = '0;
    wr_flag   = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_COMMAND_BASE: cfg_model.command_base  = data[15:0];
      CFG_CONTROL_BASE: cfg_model.control_base  = data[15:0];
      CFG_DRIVE_SELECT: cfg_model.drive_select  = data[0];
      CFG_LBA48:        cfg_model.lba48_capable = data[0];
      CFG_POLL_LIMIT:   cfg_model.poll_limit    = data[19:0];
      default: ;
    endcase
  endfunction

  // Queue one expected result; an item never yields more than 16
  function automatic void owe(input kind_e k, input logic [15:0] port,
                              input logic [15:0] val, input logic [24:0] total);
    out_item_t r;
    if (step_results >= 16) return;
    r.kind         = k;
    r.port_address = port;
    r.out_value    = val;
    r.byte_total   = total;
    r.last         = 1'b0;
    expected_q.push_back(r);
    step_results++;
  endfunction

  function automatic void taskfile_write(input logic [15:0] ofs, input logic [7:0] val);
    owe(KIND_BYTE_WR, cfg_model.command_base + ofs, {8'h00, val}, '0);
  endfunction

  function automatic void abort_request();
    owe(KIND_FAIL, '0, '0, '0);
    ph = PH_IDLE;
    requests_failed++;
  endfunction

  // Program the task file for the current sector, then wait out 400 ns
  function automatic void issue_sector();
    logic [47:0] a;
    logic [48:0] span;
    logic [7:0]  slave;
    logic        ext;
    a     = cur_lba;
    span  = {1'b0, a} + {33'd0, req_cnt};
    slave = {3'b000, cfg_model.drive_select, 4'h0};
    ext   = cfg_model.lba48_capable && (a >= LBA28_LIMIT || span > {1'b0, LBA28_LIMIT});
    if (ext) begin
      taskfile_write(OFS_DEVSEL, DEVSEL_LBA48 | slave);
      taskfile_write(OFS_COUNT, 8'h00);
      taskfile_write(OFS_LBA0, a[31:24]);
      taskfile_write(OFS_LBA1, a[39:32]);
      taskfile_write(OFS_LBA2, a[47:40]);
      taskfile_write(OFS_COUNT, 8'h01);
      taskfile_write(OFS_LBA0, a[7:0]);
      taskfile_write(OFS_LBA1, a[15:8]);
      taskfile_write(OFS_LBA2, a[23:16]);
      taskfile_write(OFS_CMD, wr_flag ? CMD_WRITE_PIO_EXT : CMD_READ_PIO_EXT);
    end else begin
      taskfile_write(OFS_DEVSEL, DEVSEL_LBA28 | slave | {4'h0, a[27:24]});
      taskfile_write(OFS_FEAT, 8'h00);
      taskfile_write(OFS_COUNT, 8'h01);
      taskfile_write(OFS_LBA0, a[7:0]);
      taskfile_write(OFS_LBA1, a[15:8]);
      taskfile_write(OFS_LBA2, a[23:16]);
      taskfile_write(OFS_CMD, wr_flag ? CMD_WRITE_PIO : CMD_READ_PIO);
    end
    repeat (4) owe(KIND_BYTE_RD, cfg_model.control_base + OFS_ALT, '0, '0);
    owe(KIND_BYTE_RD, cfg_model.command_base + OFS_CMD, '0, '0);
    ph       = PH_POLL_DATA;
    poll_cnt = 20'd1;
    word_idx = '0;
  endfunction

  // Advance to the next sector or report completion
  function automatic void finish_sector();
    logic [31:0] total;
    secs_done = secs_done + 16'd1;
    cur_lba   = cur_lba + 48'd1;
    if (secs_done >= req_cnt) begin
      total = {16'd0, req_cnt} * SectorBytes;
      if (total > {7'd0, TOTAL_MAX}) total = {7'd0, TOTAL_MAX};
      owe(KIND_DONE, '0, '0, total[24:0]);
      ph = PH_IDLE;
      requests_done++;
    end else begin
      issue_sector();
    end
  endfunction

  // Take one more status sample unless the limit is used up
  function automatic bit poll_more();
    if (poll_cnt >= cfg_model.poll_limit) return 1'b0;
    poll_cnt = poll_cnt + 20'd1;
    owe(KIND_BYTE_RD, cfg_model.command_base + OFS_CMD, '0, '0);
    return 1'b1;
  endfunction

  function automatic bit status_faulted(input logic [7:0] st);
    return st == STATUS_FLOAT || st[ST_ERR_BIT] || st[ST_DF_BIT];
  endfunction

  // Work out the results of one accepted item; returns how many
  function automatic int unsigned predict_item(input in_item_t it);
    logic [7:0] st;
    out_item_t  tail;
    step_results = 0;
    st = it.item_value[7:0];
    if ((it.opcode == OP_START_RD || it.opcode == OP_START_WR) && ph == PH_IDLE) begin
      if (it.sector_count == 16'd0) begin
        abort_request();
      end else begin
        wr_flag   = (it.opcode == OP_START_WR);
        cur_lba   = it.lba;
        req_cnt   = it.sector_count;
        secs_done = '0;
        issue_sector();
      end
    end else if (it.opcode == OP_STATUS && ph == PH_POLL_DATA) begin
      if (status_faulted(st)) begin
        abort_request();
      end else if (!st[ST_BSY_BIT] && st[ST_DRQ_BIT]) begin
        if (wr_flag) begin
          ph = PH_WRITE_DATA;
          owe(KIND_HOST_WANT, '0, '0, '0);
        end else begin
          ph = PH_READ_DATA;
          owe(KIND_WORD_RD, cfg_model.command_base + OFS_DATA, '0, '0);
        end
      end else if (!poll_more()) begin
        abort_request();
      end
    end else if (it.opcode == OP_STATUS && ph == PH_POLL_FLUSH) begin
      // The flush outcome is not checked: any end of the poll moves on
      if (status_faulted(st) || !st[ST_BSY_BIT]) finish_sector();
      else if (!poll_more()) finish_sector();
    end else if (it.opcode == OP_DEV_DATA && ph == PH_READ_DATA) begin
      owe(KIND_HOST_DATA, '0, it.item_value, '0);
      word_idx = word_idx + 9'd1;
      if (word_idx < WORDS_PER_SECTOR) owe(KIND_WORD_RD, cfg_model.command_base + OFS_DATA, '0, '0);
      else finish_sector();
    end else if (it.opcode == OP_HOST_DATA && ph == PH_WRITE_DATA) begin
      owe(KIND_WORD_WR, cfg_model.command_base + OFS_DATA, it.item_value, '0);
      word_idx = word_idx + 9'd1;
      if (word_idx < WORDS_PER_SECTOR) begin
        owe(KIND_HOST_WANT, '0, '0, '0);
      end else begin
        taskfile_write(OFS_CMD, cfg_model.lba48_capable ? CMD_FLUSH_EXT : CMD_FLUSH);
        owe(KIND_BYTE_RD, cfg_model.command_base + OFS_CMD, '0, '0);
        ph       = PH_POLL_FLUSH;
        poll_cnt = 20'd1;
      end
    end
    // Mark the final result of this item
    if (step_results > 0) begin
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
    return step_results;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid_o === 1'b1 && !out_stall_q) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t: unexpected result kind=%0d port=%h val=%h total=%0d last=%b",
                   $time, out_item_o.kind, out_item_o.port_address, out_item_o.out_value,
                   out_item_o.byte_total, out_item_o.last);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (out_item_o.kind !== want.kind ||
            out_item_o.port_address !== want.port_address ||
            out_item_o.out_value !== want.out_value ||
            out_item_o.byte_total !== want.byte_total ||
            out_item_o.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 40)
            $display({"%0t: mismatch expected kind=%0d port=%h val=%h total=%0d last=%b",
                      " actual kind=%0d port=%h val=%h total=%0d last=%b"},
                     $time, want.kind, want.port_address, want.out_value, want.byte_total,
                     want.last, out_item_o.kind, out_item_o.port_address,
                     out_item_o.out_value, out_item_o.byte_total, out_item_o.last);
        end
      end
    end
    out_stall_q <= ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one item, hold it until taken, then predict its results
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_q <= 1'b0;
      @(posedge clk);
    end
    in_valid_q <= 1'b1;
    in_item_q  <= it;
    do @(posedge clk); while (in_stall_o);
    items_sent++;
    if (predict_item(it) > 0) items_acted++;
  endtask

  // Drop valid and hold until every owed result has been taken
  task automatic wait_drained();
    in_valid_q <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Drain, then let items that cause nothing clear the pipeline
  task automatic wait_idle();
    wait_drained();
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    apply_reg(idx, data);
    cfg_valid_q <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [15:0] cmd_base, input logic [15:0] ctrl_base,
                                input logic drive, input logic ext_ok,
                                input logic [19:0] limit);
    wait_idle();
    write_reg(CFG_COMMAND_BASE, {4'h0, cmd_base});
    write_reg(CFG_CONTROL_BASE, {4'h0, ctrl_base});
    write_reg(CFG_DRIVE_SELECT, {19'd0, drive});
    write_reg(CFG_LBA48, {19'd0, ext_ok});
    write_reg(CFG_POLL_LIMIT, limit);
  endtask

  function automatic in_item_t make_item(input logic [2:0] op, input logic [47:0] lba,
                                         input logic [15:0] cnt, input logic [15:0] val);
    in_item_t it;
    it.opcode       = op;
    it.lba          = lba;
    it.sector_count = cnt;
    it.item_value   = val;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] status_fault();
    logic [7:0] s;
    s = $urandom_range(255);
    case ($urandom_range(2))
      0:       s = STATUS_FLOAT;
      1:       s[ST_ERR_BIT] = 1'b1;
      default: s[ST_DF_BIT] = 1'b1;
    endcase
    return s;
  endfunction

  // Not ready and not faulted: busy, or no data request
  function automatic logic [7:0] status_busy();
    logic [7:0] s;
    s = $urandom_range(255);
    s[ST_ERR_BIT] = 1'b0;
    s[ST_DF_BIT]  = 1'b0;
    if ($urandom_range(1)) s[ST_BSY_BIT] = 1'b1;
    else s[ST_DRQ_BIT] = 1'b0;
    return s;
  endfunction

  function automatic logic [7:0] status_ready();
    logic [7:0] s;
    s = $urandom_range(255);
    s[ST_ERR_BIT] = 1'b0;
    s[ST_DF_BIT]  = 1'b0;
    s[ST_BSY_BIT] = 1'b0;
    s[ST_DRQ_BIT] = 1'b1;
    return s;
  endfunction

  // Favor addresses around the LBA28 boundary and the top of the 48-bit range
  function automatic logic [47:0] pick_lba();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return 48'd0;
      1:       return LBA28_LIMIT_M1;
      2:       return LBA28_LIMIT;
      3:       return LBA28_LIMIT - 48'd2;
      4:       return 48'hFFFF_FFFF_FFFF;
      5:       return 48'hFFFF_FFFF_FFFE;
      6:       return w[47:0];
      default: return {20'd0, w[27:0]};
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 16'd1;
    if (r < 77) return 16'd2;
    if (r < 87) return 16'd0;
    if (r < 95) return 16'($urandom_range(8, 3));
    return 16'($urandom);
  endfunction

  // Build an item that fits the current phase; a few are random noise.
  // While winding down, the next data poll is failed to end the request.
  function automatic in_item_t next_stimulus(input bit winding);
    in_item_t    it;
    logic [63:0] w;
    int unsigned r;
    w = {$urandom, $urandom};
    it.opcode       = $urandom_range(4);
    it.lba          = w[47:0];
    it.sector_count = $urandom;
    it.item_value   = $urandom;
    r = $urandom_range(99);
    if (!winding && r >= 95) return it;
    case (ph)
      PH_IDLE: begin
        it.opcode       = $urandom_range(1) ? OP_START_WR : OP_START_RD;
        it.lba          = pick_lba();
        it.sector_count = pick_count();
      end
      PH_POLL_DATA: begin
        it.opcode = OP_STATUS;
        if (winding || r < 5) it.item_value[7:0] = status_fault();
        else if (r < 35) it.item_value[7:0] = status_busy();
        else it.item_value[7:0] = status_ready();
      end
      PH_READ_DATA:  it.opcode = OP_DEV_DATA;
      PH_WRITE_DATA: it.opcode = OP_HOST_DATA;
      default: begin
        it.opcode = OP_STATUS;
        if (r < 45) it.item_value[7:0] = status_busy() | 8'h80;
      end
    endcase
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero sector count fails at once, with reset register values in use
  task automatic test_zero_count();
    send_item(make_item(OP_START_RD, 48'hFFFF_FFFF_FFFF, 16'd0, 16'hFFFF));
    send_item(make_item(OP_START_WR, 48'd0, 16'd0, 16'h0000));
  endtask

  // LBA28 read, busy and no-DRQ polls, then a floating bus
  task automatic test_lba28_read();
    send_item(make_item(OP_START_RD, 48'h0000_0ABC_DEF1, 16'hFFFF, 16'd0));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'hFF80));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0000));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h00FF));
  endtask

  // Status and data words while idle are dropped
  task automatic test_ignored_items();
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0008));
    send_item(make_item(OP_DEV_DATA, 48'd0, 16'd0, 16'hA5A5));
    send_item(make_item(OP_HOST_DATA, 48'd0, 16'd0, 16'h5A5A));
  endtask

  // LBA48 selection around the boundary, slave drive, busy-time drops
  task automatic test_lba48_forms();
    wait_idle();
    write_reg(CFG_LBA48, 20'd1);
    write_reg(CFG_DRIVE_SELECT, 20'd1);
    send_item(make_item(OP_START_WR, LBA28_LIMIT_M1, 16'd1, 16'd0));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0009));
    send_item(make_item(OP_START_RD, LBA28_LIMIT_M1, 16'd2, 16'd0));
    send_item(make_item(OP_START_WR, 48'd5, 16'd1, 16'd0));
    send_item(make_item(OP_DEV_DATA, 48'd0, 16'd0, 16'h1234));
    send_item(make_item(OP_HOST_DATA, 48'd0, 16'd0, 16'h4321));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0028));
    send_item(make_item(OP_START_RD, LBA28_LIMIT, 16'd1, 16'd0));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h00FF));
    send_item(make_item(OP_START_WR, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'd0));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h00A1));
  endtask

  // Poll limit reached on a not-ready status
  task automatic test_poll_timeout();
    wait_idle();
    write_reg(CFG_POLL_LIMIT, 20'd1);
    write_reg(CFG_LBA48, 20'd0);
    send_item(make_item(OP_START_RD, 48'd100, 16'd1, 16'd0));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0088));
    wait_idle();
    write_reg(CFG_POLL_LIMIT, 20'd3);
    send_item(make_item(OP_START_WR, 48'd7, 16'd1, 16'd0));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0000));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0080));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0050));
  endtask

  // Port bases at the top of the range wrap around
  task automatic test_port_extremes();
    write_all_regs(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, POLL_LIMIT_RESET);
    send_item(make_item(OP_START_RD, LBA28_LIMIT, 16'd1, 16'd0));
    send_item(make_item(OP_STATUS, 48'd0, 16'd0, 16'h0001));
  endtask

  // Phase-aware traffic; pauses once mid-run until all results are back
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned budget);
    int unsigned base;
    bit          paused;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    base   = items_acted;
    paused = 1'b0;
    while (items_acted - base < budget || ph != PH_IDLE) begin
      if (!paused && items_acted - base >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_item(next_stimulus(items_acted - base >= budget));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_count();
    test_lba28_read();
    test_ignored_items();
    test_lba48_forms();
    test_poll_timeout();
    test_port_extremes();

    write_all_regs(CMD_BASE_RESET, CTRL_BASE_RESET, 1'b0, 1'b1, 20'd6);
    test_random_traffic(0, 0, 700);
    write_all_regs(16'h0000, 16'hFFFF, 1'b1, 1'b0, 20'd1);
    test_random_traffic(81, 0, 700);
    write_all_regs(16'($urandom), 16'($urandom), 1'b0, 1'b1, 20'hFFFFF);
    test_random_traffic(0, 81, 700);
    write_all_regs(16'($urandom), 16'($urandom), 1'b1, 1'b1, 20'd3);
    test_random_traffic(38, 38, 700);

    wait_idle();
    $display("Run covered %0d items (%0d acted on) and %0d checked results",
             items_sent, items_acted, results_checked);
    $display("Requests: %0d completed, %0d failed, over four idle/stall patterns",
             requests_done, requests_failed);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/apss_pkg.sv
hw/rtl/apss_front.sv
hw/rtl/apss_queue.sv
hw/rtl/apss_back.sv
hw/rtl/ata_pio_sector_sequencer_top.sv
tb/ata_pio_sector_sequencer_top_tb.sv
